FILE: rtl/otp_pkg.sv
`timescale 1ns / 1ps

package otp_pkg;

	// converter resolution and rail code
	localparam int ADC_BITS = 10;
	localparam int ADC_FULL = (1 << ADC_BITS) - 1;
	localparam int ROM_DEPTH = 1 << ADC_BITS;

	localparam int TEMP_W = 17;
	localparam int KELVIN_CENTI = 27315;
	localparam int CFG_IDX_W = 3;
	localparam int LIMIT_W = 8;

	// steinhart-hart setup
	localparam real SH_A = 1.009249522e-03;
	localparam real SH_B = 2.378405444e-04;
	localparam real SH_C = 2.019202697e-07;
	localparam real SH_KELVIN = 273.15;
	localparam real SH_R1 = 10000.0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLT  = 3'd0,
		REG_CURR  = 3'd1,
		REG_POW   = 3'd2,
		REG_ENER  = 3'd3,
		REG_TEMP  = 3'd4,
		REG_ALARM = 3'd5,
		REG_DIS   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] volt;
		logic [LIMIT_W-1:0] curr;
		logic [LIMIT_W-1:0] pow;
		logic [LIMIT_W-1:0] ener;
		logic [LIMIT_W-1:0] temp;
	} limits_t;

endpackage

FILE: rtl/overlimit_trip_protector.sv
`timescale 1ns / 1ps
// overlimit trip protector for one socket
// readings and the rom read are latched into stage 1 on accept; the compares land in the
// result register when it is free (empty or being taken)
// throughput: one item per cycle while out_ready keeps the result register draining
// reset: limits, alarm enable and disable cleared, trip flag cleared, pipeline
// empty; rom contents are constant and need no clearing

module overlimit_trip_protector (
	input  logic                               clk,
	input  logic                               arst_n,

	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [otp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [7:0]                         cfg_data,

	// sampling round in
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [11:0]                        meter_voltage,
	input  logic [16:0]                        meter_current,
	input  logic [17:0]                        meter_power,
	input  logic [23:0]                        meter_energy,
	input  logic                               meter_valid,
	input  logic [9:0]                         thermistor_code,

	// result out
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               relay_closed,
	output logic                               alarm_lamp,
	output logic signed [16:0]                 temperature_centi,
	output logic [4:0]                         limits_hit
);

	// configuration registers
	otp_pkg::limits_t limits_q;
	logic             alarm_en_q;
	logic             disabled_q;

	// sticky trip flag
	logic tripped_q;

	// stage 1: latched readings, rom output registered alongside
	logic        v_s1;
	logic [11:0] volt_s1;
	logic [16:0] curr_s1;
	logic [17:0] pow_s1;
	logic [23:0] ener_s1;
	logic        mvalid_s1;
	logic signed [otp_pkg::TEMP_W-1:0] temp_s1;

	// stage 2: result register
	logic        out_valid_q;
	logic        relay_q;
	logic        lamp_q;
	logic signed [otp_pkg::TEMP_W-1:0] temp_q;
	logic [4:0]  hits_q;

	logic        adv_s2;
	logic        load_s1;
	logic [4:0]  hits_raw;
	logic [4:0]  hits_s2;
	logic        trip_next;

	// the result register frees when empty or taken; stage 1 moves into it then
	assign adv_s2   = !out_valid_q || out_ready;
	assign in_ready = !v_s1 || adv_s2;
	assign load_s1  = in_valid && in_ready;

	// config is never stalled
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q   <= '0;
			alarm_en_q <= 1'b0;
			disabled_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				otp_pkg::REG_VOLT:  limits_q.volt <= cfg_data;
				otp_pkg::REG_CURR:  limits_q.curr <= cfg_data;
				otp_pkg::REG_POW:   limits_q.pow  <= cfg_data;
				otp_pkg::REG_ENER:  limits_q.ener <= cfg_data;
				otp_pkg::REG_TEMP:  limits_q.temp <= cfg_data;
				otp_pkg::REG_ALARM: alarm_en_q    <= cfg_data[0];
				otp_pkg::REG_DIS:   disabled_q    <= cfg_data[0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	// thermistor code to centi-degrees, read lands in stage 1
	otp_temp_rom u_rom (
		.clk  (clk),
		.en   (load_s1),
		.addr (thermistor_code),
		.data (temp_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			volt_s1   <= meter_voltage;
			curr_s1   <= meter_current;
			pow_s1    <= meter_power;
			ener_s1   <= meter_energy;
			mvalid_s1 <= meter_valid;
		end
	end

	otp_limit_cmp u_cmp (
		.limits   (limits_q),
		.voltage  (volt_s1),
		.current  (curr_s1),
		.power    (pow_s1),
		.energy   (ener_s1),
		.meter_ok (mvalid_s1),
		.temp     (temp_s1),
		.hits     (hits_raw)
	);

	// disabled: nothing counts and the trip flag stays put
	assign hits_s2   = disabled_q ? 5'd0 : hits_raw;
	assign trip_next = tripped_q || (hits_s2 != 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tripped_q   <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= v_s1;
			if (v_s1) begin
				tripped_q <= trip_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			relay_q <= !disabled_q && !trip_next;
			lamp_q  <= !disabled_q && trip_next && alarm_en_q;
			temp_q  <= temp_s1;
			hits_q  <= hits_s2;
		end
	end

	assign out_valid         = out_valid_q;
	assign relay_closed      = relay_q;
	assign alarm_lamp        = lamp_q;
	assign temperature_centi = temp_q;
	assign limits_hit        = hits_q;

	// trip flag is sticky
	a_trip_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		tripped_q |=> tripped_q)
		else $error("trip flag cleared without reset");

	// relay closed and lamp lit never together
	a_relay_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && relay_closed |-> !alarm_lamp)
		else $error("lamp lit with relay closed");

	// a limit reached this round always opens the relay
	a_hit_opens: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (limits_hit != 5'd0) |-> !relay_closed)
		else $error("limit hit but relay closed");

	// input side only stalls when both stages are full and output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && out_valid_q && !out_ready)
		else $error("input stalled without backpressure");

endmodule

FILE: rtl/otp_temp_rom.sv
`timescale 1ns / 1ps

module otp_temp_rom (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [otp_pkg::ADC_BITS-1:0]           addr,
	output logic signed [otp_pkg::TEMP_W-1:0]      data
);

	logic signed [otp_pkg::TEMP_W-1:0] rom_tbl [otp_pkg::ROM_DEPTH];
	logic signed [otp_pkg::TEMP_W-1:0] data_q;

	// centi-degrees for every converter code, rounded to nearest; rails read as absolute zero
	for (genvar g = 0; g < otp_pkg::ROM_DEPTH; g++) begin : g_entry
		localparam bit  RAIL = (g == 0) || (g >= otp_pkg::ADC_FULL);
		// rails take a harmless code so the log stays finite
		localparam int  CODE = RAIL ? 1 : g;
		localparam real LN_R2 = $ln(otp_pkg::SH_R1) + $ln(real'(otp_pkg::ADC_FULL - CODE))
			- $ln(real'(CODE));
		localparam real KELVIN = 1.0 / (otp_pkg::SH_A + otp_pkg::SH_B * LN_R2
			+ otp_pkg::SH_C * LN_R2 * LN_R2 * LN_R2);
		localparam int  CENTI = RAIL ? -otp_pkg::KELVIN_CENTI
			: $rtoi($floor(100.0 * KELVIN + 0.5)) - otp_pkg::KELVIN_CENTI;
		assign rom_tbl[g] = CENTI[otp_pkg::TEMP_W-1:0];
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= rom_tbl[addr];
		end
	end

	assign data = data_q;

endmodule

FILE: rtl/otp_limit_cmp.sv
`timescale 1ns / 1ps

module otp_limit_cmp (
	input  otp_pkg::limits_t                   limits,
	input  logic [11:0]                        voltage,
	input  logic [16:0]                        current,
	input  logic [17:0]                        power,
	input  logic [23:0]                        energy,
	input  logic                               meter_ok,
	input  logic signed [otp_pkg::TEMP_W-1:0]  temp,
	output logic [4:0]                         hits
);

	logic [11:0] volt_thr;
	logic [17:0] curr_thr;
	logic [17:0] pow_thr;
	logic [11:0] ener_thr;
	logic [14:0] temp_thr;

	// scale limits to reading units
	assign volt_thr = 12'(limits.volt) * 12'd10;
	assign curr_thr = 18'(limits.curr) * 18'd1000;
	assign pow_thr  = 18'(limits.pow) * 18'd1000;
	assign ener_thr = 12'(limits.ener) * 12'd10;
	assign temp_thr = 15'(limits.temp) * 15'd100;

	always_comb begin
		hits[0] = meter_ok && (voltage >= volt_thr);
		hits[1] = meter_ok && ({1'b0, current} >= curr_thr);
		hits[2] = meter_ok && (power >= pow_thr);
		hits[3] = meter_ok && (energy >= {12'd0, ener_thr});
		hits[4] = temp >= $signed({2'b00, temp_thr});
	end

endmodule

FILE: sim/protection_checker.sv
`timescale 1ns / 1ps

module protection_checker
	import otp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,

	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [11:0]          meter_voltage,
	input  logic [16:0]          meter_current,
	input  logic [17:0]          meter_power,
	input  logic [23:0]          meter_energy,
	input  logic                 meter_valid,
	input  logic [9:0]           thermistor_code,

	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 relay_closed,
	input  logic                 alarm_lamp,
	input  logic signed [16:0]   temperature_centi,
	input  logic [4:0]           limits_hit,

	output int                   errors,
	output int                   pending
);

	localparam int  CODE_FULL = (1 << ADC_BITS) - 1;
	localparam int  ABS_ZERO_CENTI = 27315;
	localparam real COEF_A = 1.009249522e-03;
	localparam real COEF_B = 2.378405444e-04;
	localparam real COEF_C = 2.019202697e-07;
	localparam real DIVIDER_OHMS = 10000.0;

	typedef struct {
		logic               relay;
		logic               lamp;
		logic signed [16:0] centi;
		logic [4:0]         hits;
	} round_result_t;

	int            centi_table [ROM_DEPTH];
	limits_t       limit_regs;
	logic          alarm_on;
	logic          outputs_off;
	logic          trip_latched;
	round_result_t expected_rounds [$];

	// thermistor code to centi-degrees, rails read as absolute zero
	initial begin
		real ln_r;
		real kelvin;
		for (int c = 0; c < ROM_DEPTH; c++) begin
			if (c == 0 || c >= CODE_FULL) begin
				centi_table[c] = -ABS_ZERO_CENTI;
			end else begin
				ln_r = $ln(DIVIDER_OHMS) + $ln(real'(CODE_FULL - c)) - $ln(real'(c));
				kelvin = 1.0 / (COEF_A + COEF_B * ln_r + COEF_C * ln_r * ln_r * ln_r);
				centi_table[c] = $rtoi($floor(kelvin * 100.0 + 0.5)) - ABS_ZERO_CENTI;
			end
		end
	end

	function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
		case (reg_idx_t'(idx))
			REG_VOLT: begin
				limit_regs.volt = data;
			end
			REG_CURR: begin
				limit_regs.curr = data;
			end
			REG_POW: begin
				limit_regs.pow = data;
			end
			REG_ENER: begin
				limit_regs.ener = data;
			end
			REG_TEMP: begin
				limit_regs.temp = data;
			end
			REG_ALARM: begin
				alarm_on = data[0];
			end
			REG_DIS: begin
				outputs_off = data[0];
			end
			default: begin
			end
		endcase
	endfunction

	// one sampling round: limit compares, sticky trip, relay and lamp
	function automatic round_result_t protect_round(logic [11:0] volts, logic [16:0] amps,
			logic [17:0] watts, logic [23:0] energy, logic meter_ok, logic [9:0] code);
		round_result_t res;
		res.centi = 17'(centi_table[code]);
		res.hits = '0;
		if (!outputs_off) begin
			if (meter_ok) begin
				res.hits[0] = int'(volts) >= 10 * int'(limit_regs.volt);
				res.hits[1] = int'(amps) >= 1000 * int'(limit_regs.curr);
				res.hits[2] = int'(watts) >= 1000 * int'(limit_regs.pow);
				res.hits[3] = int'(energy) >= 10 * int'(limit_regs.ener);
			end
			res.hits[4] = int'(res.centi) >= 100 * int'(limit_regs.temp);
			if (res.hits != '0)
				trip_latched = 1'b1;
		end
		res.relay = !outputs_off && !trip_latched;
		res.lamp = !outputs_off && trip_latched && alarm_on;
		return res;
	endfunction

	task automatic check_field(string field, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		round_result_t want;
		if (!arst_n) begin
			limit_regs = '0;
			alarm_on = 1'b0;
			outputs_off = 1'b0;
			trip_latched = 1'b0;
			expected_rounds.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (in_valid && in_ready)
				expected_rounds.push_back(protect_round(meter_voltage, meter_current,
					meter_power, meter_energy, meter_valid, thermistor_code));
			if (out_valid && out_ready) begin
				if (expected_rounds.size() == 0) begin
					$error("result item with no round waiting for it");
					errors++;
				end else begin
					want = expected_rounds.pop_front();
					check_field("relay_closed", want.relay, relay_closed);
					check_field("alarm_lamp", want.lamp, alarm_lamp);
					check_field("temperature_centi", want.centi, temperature_centi);
					check_field("limits_hit", want.hits, limits_hit);
				end
			end
		end
		pending = expected_rounds.size();
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import otp_pkg::*;

	// spare index past the last register, a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// one sampling round as driven on the input channel
	typedef struct {
		logic [11:0] voltage;
		logic [16:0] current;
		logic [17:0] power;
		logic [23:0] energy;
		logic        valid;
		logic [9:0]  code;
	} round_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [11:0]          meter_voltage;
	logic [16:0]          meter_current;
	logic [17:0]          meter_power;
	logic [23:0]          meter_energy;
	logic                 meter_valid;
	logic [9:0]           thermistor_code;
	logic                 out_valid;
	logic                 out_ready;
	logic                 relay_closed;
	logic                 alarm_lamp;
	logic signed [16:0]   temperature_centi;
	logic [4:0]           limits_hit;

	int errors;
	int pending;

	// idling knobs, percent of cycles
	int send_idle_pct;
	int stall_pct;
	int idle_step;

	// limits as last written, used only to aim stimulus at the trip points
	logic [7:0] lim_shadow [5];

	overlimit_trip_protector DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.meter_voltage     (meter_voltage),
		.meter_current     (meter_current),
		.meter_power       (meter_power),
		.meter_energy      (meter_energy),
		.meter_valid       (meter_valid),
		.thermistor_code   (thermistor_code),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.relay_closed      (relay_closed),
		.alarm_lamp        (alarm_lamp),
		.temperature_centi (temperature_centi),
		.limits_hit        (limits_hit)
	);

	// watches all three channels, predicts every result item and compares
	protection_checker trip_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.meter_voltage     (meter_voltage),
		.meter_current     (meter_current),
		.meter_power       (meter_power),
		.meter_energy      (meter_energy),
		.meter_valid       (meter_valid),
		.thermistor_code   (thermistor_code),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.relay_closed      (relay_closed),
		.alarm_lamp        (alarm_lamp),
		.temperature_centi (temperature_centi),
		.limits_hit        (limits_hit),
		.errors            (errors),
		.pending           (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side back-pressure, changes only at the falling edge
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= stall_pct);
	end

	// idling pattern cycles through: none, sender gaps, receiver stalls, both
	task automatic set_idling(int step);
		case (step % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 50;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 50;
			end
			default: begin
				send_idle_pct = 14;
				stall_pct = 14;
			end
		endcase
	endtask

	// register write, only issued while nothing is in flight
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx <= REG_TEMP)
			lim_shadow[idx] = data;
	endtask

	task automatic set_limits(logic [7:0] volt, logic [7:0] curr, logic [7:0] pow,
			logic [7:0] ener, logic [7:0] temp);
		write_reg(REG_VOLT, volt);
		write_reg(REG_CURR, curr);
		write_reg(REG_POW, pow);
		write_reg(REG_ENER, ener);
		write_reg(REG_TEMP, temp);
	endtask

	// drop valid and wait until every expected result item has come back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		// pipeline is two deep, let it settle before going on
		repeat (4) @(negedge clk);
	endtask

	// one item on the input channel; valid stays up until accepted
	task automatic send_round(round_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		meter_voltage = r.voltage;
		meter_current = r.current;
		meter_power = r.power;
		meter_energy = r.energy;
		meter_valid = r.valid;
		thermistor_code = r.code;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic round_t make_round(int volt, int curr, int pow, int ener,
			logic ok, int code);
		round_t r;
		r.voltage = 12'(volt);
		r.current = 17'(curr);
		r.power = 18'(pow);
		r.energy = 24'(ener);
		r.valid = ok;
		r.code = 10'(code);
		return r;
	endfunction

	// value aimed at a trip point: anywhere, right at it, below it or above it
	function automatic int near_threshold(int thr, int width);
		int top;
		int v;
		top = (1 << width) - 1;
		case ($urandom_range(3))
			0: v = $urandom & top;
			1: v = thr - 1 + $urandom_range(2);
			2: v = $urandom_range(thr);
			default: v = thr + $urandom_range(1000);
		endcase
		if (v < 0)
			v = 0;
		if (v > top)
			v = top;
		return v;
	endfunction

	function automatic logic [7:0] pick_limit();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// safe rounds keep valid readings and temperature under the 255 limits so
	// the sticky trip stays clear; invalid meters may carry anything
	function automatic round_t random_round(bit safe);
		round_t r;
		r.valid = ($urandom_range(3) != 0);
		if (safe && r.valid) begin
			r.voltage = 12'($urandom_range(2549));
			r.current = 17'($urandom);
			r.power = 18'($urandom_range(254999));
			r.energy = 24'($urandom_range(2549));
		end else begin
			r.voltage = 12'(near_threshold(10 * int'(lim_shadow[REG_VOLT]), 12));
			r.current = 17'(near_threshold(1000 * int'(lim_shadow[REG_CURR]), 17));
			r.power = 18'(near_threshold(1000 * int'(lim_shadow[REG_POW]), 18));
			r.energy = 24'(near_threshold(10 * int'(lim_shadow[REG_ENER]), 24));
		end
		// codes 1019 to 1022 read hotter than 255 degrees; 1023 is a rail
		case ($urandom_range(7))
			0: r.code = 10'd0;
			1: r.code = safe ? 10'd1 : 10'd1022;
			2: r.code = 10'd1023;
			default: r.code = safe ? 10'($urandom_range(1010)) : 10'($urandom);
		endcase
		return r;
	endfunction

	task automatic run_random(int count, bit safe);
		for (int i = 0; i < count; i++) begin
			if (i % 20 == 0) begin
				set_idling(idle_step);
				idle_step++;
			end
			// now and then let everything drain before going on
			if ($urandom_range(49) == 0)
				drain();
			send_round(random_round(safe));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		meter_voltage = '0;
		meter_current = '0;
		meter_power = '0;
		meter_energy = '0;
		meter_valid = 1'b0;
		thermistor_code = '0;
		out_ready = 1'b1;
		send_idle_pct = 0;
		stall_pct = 0;
		idle_step = 0;
		foreach (lim_shadow[i])
			lim_shadow[i] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero limits would trip on the first valid reading, so open them up first;
		// the spare index gets a write that must be ignored
		set_limits(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		write_reg(REG_ALARM, 8'd0);
		write_reg(REG_DIS, 8'd0);
		write_reg(REG_UNUSED, 8'hff);

		// untripped: zero reading, just under every limit, invalid meter with
		// everything maxed, both rails and the coldest code
		send_round(make_round(0, 0, 0, 0, 1'b1, 512));
		send_round(make_round(2549, 131071, 254999, 2549, 1'b1, 1010));
		send_round(make_round(4095, 131071, 262143, 16777215, 1'b0, 1023));
		send_round(make_round(0, 0, 0, 0, 1'b0, 0));
		send_round(make_round(7, 3, 5, 9, 1'b1, 1));
		run_random(60, 1'b1);

		// disabled: rounds over the limits must not trip, outputs forced off
		drain();
		write_reg(REG_DIS, 8'd1);
		send_round(make_round(4095, 131071, 262143, 16777215, 1'b1, 1022));
		send_round(make_round(4095, 131071, 262143, 16777215, 1'b1, 0));
		run_random(40, 1'b0);

		// back on with the alarm off: the voltage limit reached exactly trips it
		drain();
		write_reg(REG_DIS, 8'd0);
		send_round(make_round(2550, 0, 0, 0, 1'b1, 512));
		send_round(make_round(0, 131071, 255000, 2550, 1'b1, 512));
		send_round(make_round(0, 0, 0, 0, 1'b0, 1022));

		// tripped with the alarm on lights the lamp
		drain();
		write_reg(REG_ALARM, 8'd1);
		send_round(make_round(0, 0, 0, 0, 1'b1, 300));

		// disabling after a trip darkens everything but keeps the trip
		drain();
		write_reg(REG_DIS, 8'd1);
		send_round(make_round(4095, 131071, 262143, 16777215, 1'b1, 700));
		drain();
		write_reg(REG_DIS, 8'd0);
		send_round(make_round(0, 0, 0, 0, 1'b1, 300));

		// all limits zero: any valid reading hits, temperature from 0 degrees up
		drain();
		set_limits(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_round(make_round(0, 0, 0, 0, 1'b1, 512));
		send_round(make_round(0, 0, 0, 0, 1'b0, 1));
		send_round(make_round(0, 0, 0, 0, 1'b0, 1023));

		// one under the top limits
		drain();
		set_limits(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		send_round(make_round(2549, 131071, 254999, 2549, 1'b1, 1010));

		// random phases over several settings, extremes first, one disabled
		for (int ph = 0; ph < 7; ph++) begin
			drain();
			case (ph)
				0: set_limits(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
				1: set_limits(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
				default: set_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit(),
					pick_limit());
			endcase
			write_reg(REG_ALARM, 8'($urandom_range(1)));
			write_reg(REG_DIS, (ph == 4) ? 8'd1 : 8'd0);
			run_random(55, 1'b0);
		end

		drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/otp_pkg.sv
rtl/otp_temp_rom.sv
rtl/otp_limit_cmp.sv
rtl/overlimit_trip_protector.sv
sim/protection_checker.sv
sim/tb.sv
